// File: hw/rtl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// shared types and constants of the antialiased pixel splat block
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int CH_W       = 8;   // one colour channel
  localparam int COORD_W    = 4;   // integer part of a position
  localparam int FRAC_W     = 8;   // fraction part of a position
  localparam int PIX_W      = 3 * CH_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WGT,
    ST_SCR,
    ST_SCG,
    ST_SCB,
    ST_UPD,
    ST_RD,
    ST_RDW,
    ST_OUT
  } state_t;

  // input command codes
  typedef enum logic {
    CMD_SPLAT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // shared multiply unit operations
  typedef enum logic {
    MAC_WEIGHT,   // (a*b + a + b) >> 8
    MAC_SCALE     // (a*b) >> 8
  } mac_kind_t;

  typedef struct packed {
    mac_kind_t       kind;
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
  } mac_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } fb_ctl_t;

endpackage

// File: hw/rtl/antialiased_pixel_splat.sv
// ----------------------------------------------------------------------------
// antialiased_pixel_splat
// sub-pixel bilinear splat into an rgb frame memory, with pixel read-back
// ----------------------------------------------------------------------------
// splat in range: per touched pixel, one weight and three channel products
//   through the single 8x8 multiplier, one memory read-modify-write and one
//   output transfer (states WGT, SCR, SCG, SCB, UPD, OUT), after the accept
// pixel read: RD, RDW, OUT; dropped item: OUT; one item in flight at a time
// reset: sweep zeroes the frame memory, with in_tready low until it is done,
//   before the first transaction is taken
// ----------------------------------------------------------------------------
module antialiased_pixel_splat #(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x[11:0], pos_y[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
  input  logic [aps_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[0]
  input  logic [0:0]                       in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_col[3:0], pixel_row[7:4], red_out[15:8], green_out[23:16],
  // blue_out[31:24]
  output logic [aps_pkg::OUT_DATA_W-1:0]   out_tdata,
  // dropped[0]
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int DEPTH  = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = aps_pkg::CH_W;
  localparam int CW     = aps_pkg::COORD_W;
  localparam int FW     = aps_pkg::FRAC_W;
  // coordinates are widened to nine bits for the compares
  localparam int LIM_W  = 9;
  localparam logic [LIM_W-1:0] COL_END   = LIM_W'(MATRIX_WIDTH);
  localparam logic [LIM_W-1:0] ROW_END   = LIM_W'(MATRIX_HEIGHT);
  localparam logic [LIM_W-1:0] COL_SPLAT = LIM_W'(MATRIX_WIDTH - 1);
  localparam logic [LIM_W-1:0] ROW_SPLAT = LIM_W'(MATRIX_HEIGHT - 1);

  // input field unpacking
  aps_pkg::cmd_t   in_cmd;
  logic [CW-1:0]   in_col;
  logic [CW-1:0]   in_row;
  logic [FW-1:0]   in_fx;
  logic [FW-1:0]   in_fy;
  logic            in_acc;
  logic            in_range;

  assign in_cmd = aps_pkg::cmd_t'(in_tuser[0]);
  assign in_fx  = in_tdata[7:0];
  assign in_col = in_tdata[11:8];
  assign in_fy  = in_tdata[19:12];
  assign in_row = in_tdata[23:20];
  assign in_acc = in_tvalid && in_tready;

  // reads need the pixel itself, splats also the right and lower neighbors
  always_comb begin
    if (in_cmd == aps_pkg::CMD_READ) begin
      in_range = (LIM_W'(in_col) < COL_END) && (LIM_W'(in_row) < ROW_END);
    end else begin
      in_range = (LIM_W'(in_col) < COL_SPLAT) && (LIM_W'(in_row) < ROW_SPLAT);
    end
  end

  // sequencer and item registers
  aps_pkg::state_t   state_r;
  aps_pkg::state_t   state_nxt;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     row_r;
  logic [FW-1:0]     fx_r;
  logic [FW-1:0]     fy_r;
  logic [CH_W-1:0]   red_r;
  logic [CH_W-1:0]   green_r;
  logic [CH_W-1:0]   blue_r;
  logic [1:0]        idx_r;      // which of the four pixels
  logic [CH_W-1:0]   w_r;        // weight of the current pixel
  logic [CH_W-1:0]   sr_r;       // scaled red
  logic [CH_W-1:0]   sg_r;       // scaled green

  // result registers
  logic [CW-1:0]     out_col_r;
  logic [CW-1:0]     out_row_r;
  logic [CH_W-1:0]   out_red_r;
  logic [CH_W-1:0]   out_green_r;
  logic [CH_W-1:0]   out_blue_r;
  logic              out_drop_r;
  logic              out_last_r;

  // shared unit and memory hookup
  aps_pkg::mac_op_t           mac_op;
  logic [CH_W-1:0]            mac_res;
  aps_pkg::fb_ctl_t           fb_ctl;
  logic [aps_pkg::PIX_W-1:0]  fb_rd;
  logic [aps_pkg::PIX_W-1:0]  new_pix;
  logic                       fb_busy;
  logic [CW:0]                pix_col;   // one bit more: col+1 may pass 15
  logic [CW:0]                pix_row;
  logic [ADDR_W-1:0]          pix_addr;

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
  endfunction

  assign pix_col  = (CW+1)'(col_r) + (CW+1)'(idx_r[0]);
  assign pix_row  = (CW+1)'(row_r) + (CW+1)'(idx_r[1]);
  assign pix_addr = ADDR_W'(pix_row) * ADDR_W'(MATRIX_WIDTH) + ADDR_W'(pix_col);

  // memory word is {red, green, blue}; blue product arrives in the update cycle
  assign new_pix = {sat_add(fb_rd[23:16], sr_r),
                    sat_add(fb_rd[15:8],  sg_r),
                    sat_add(fb_rd[7:0],   mac_res)};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aps_pkg::ST_CLEAR: begin
        if (!fb_busy) begin
          state_nxt = aps_pkg::ST_IDLE;
        end
      end
      aps_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_range) begin
            state_nxt = aps_pkg::ST_OUT;
          end else if (in_cmd == aps_pkg::CMD_READ) begin
            state_nxt = aps_pkg::ST_RD;
          end else begin
            state_nxt = aps_pkg::ST_WGT;
          end
        end
      end
      aps_pkg::ST_WGT: state_nxt = aps_pkg::ST_SCR;
      aps_pkg::ST_SCR: state_nxt = aps_pkg::ST_SCG;
      aps_pkg::ST_SCG: state_nxt = aps_pkg::ST_SCB;
      aps_pkg::ST_SCB: state_nxt = aps_pkg::ST_UPD;
      aps_pkg::ST_UPD: state_nxt = aps_pkg::ST_OUT;
      aps_pkg::ST_RD:  state_nxt = aps_pkg::ST_RDW;
      aps_pkg::ST_RDW: state_nxt = aps_pkg::ST_OUT;
      aps_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = out_last_r ? aps_pkg::ST_IDLE : aps_pkg::ST_WGT;
        end
      end
      default: state_nxt = aps_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    fb_ctl.rd_en = 1'b0;
    fb_ctl.wr_en = 1'b0;
    mac_op.kind  = aps_pkg::MAC_SCALE;
    mac_op.a     = red_r;
    mac_op.b     = w_r;
    unique case (state_r)
      aps_pkg::ST_IDLE: in_tready = 1'b1;
      aps_pkg::ST_WGT: begin
        // inverse fraction is 255 - f, i.e. the bitwise complement
        mac_op.kind  = aps_pkg::MAC_WEIGHT;
        mac_op.a     = idx_r[0] ? fx_r : ~fx_r;
        mac_op.b     = idx_r[1] ? fy_r : ~fy_r;
        fb_ctl.rd_en = 1'b1;
      end
      aps_pkg::ST_SCR: begin
        mac_op.a = red_r;
        mac_op.b = mac_res;      // weight straight from the unit
      end
      aps_pkg::ST_SCG: mac_op.a = green_r;
      aps_pkg::ST_SCB: mac_op.a = blue_r;
      aps_pkg::ST_UPD: fb_ctl.wr_en = 1'b1;
      aps_pkg::ST_RD:  fb_ctl.rd_en = 1'b1;
      aps_pkg::ST_OUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aps_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item and result datapath
  always_ff @(posedge clk) begin
    if (state_r == aps_pkg::ST_IDLE && in_acc) begin
      col_r       <= in_col;
      row_r       <= in_row;
      fx_r        <= in_fx;
      fy_r        <= in_fy;
      red_r       <= in_tdata[31:24];
      green_r     <= in_tdata[39:32];
      blue_r      <= in_tdata[47:40];
      idx_r       <= 2'd0;
      // dropped result by default, replaced when the item is in range
      out_col_r   <= in_col;
      out_row_r   <= in_row;
      out_red_r   <= '0;
      out_green_r <= '0;
      out_blue_r  <= '0;
      out_drop_r  <= 1'b1;
      out_last_r  <= 1'b1;
    end
    if (state_r == aps_pkg::ST_SCR) begin
      w_r <= mac_res;
    end
    if (state_r == aps_pkg::ST_SCG) begin
      sr_r <= mac_res;
    end
    if (state_r == aps_pkg::ST_SCB) begin
      sg_r <= mac_res;
    end
    if (state_r == aps_pkg::ST_UPD) begin
      out_col_r   <= pix_col[CW-1:0];
      out_row_r   <= pix_row[CW-1:0];
      out_red_r   <= new_pix[23:16];
      out_green_r <= new_pix[15:8];
      out_blue_r  <= new_pix[7:0];
      out_drop_r  <= 1'b0;
      out_last_r  <= (idx_r == 2'd3);
    end
    if (state_r == aps_pkg::ST_RDW) begin
      out_red_r   <= fb_rd[23:16];
      out_green_r <= fb_rd[15:8];
      out_blue_r  <= fb_rd[7:0];
      out_drop_r  <= 1'b0;
      out_last_r  <= 1'b1;
    end
    if (state_r == aps_pkg::ST_OUT && out_tready && !out_last_r) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  aps_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .res (mac_res)
  );

  aps_frame #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fb_ctl),
    .rd_addr (pix_addr),
    .wr_addr (pix_addr),
    .wr_data (new_pix),
    .rd_data (fb_rd),
    .busy    (fb_busy)
  );

  assign out_tdata = {out_blue_r, out_green_r, out_red_r, out_row_r, out_col_r};
  assign out_tuser = out_drop_r;
  assign out_tlast = out_last_r;

endmodule

// File: hw/rtl/aps_mac.sv
// ----------------------------------------------------------------------------
// aps_mac
// shared 8x8 multiply unit, result registered, high byte kept
// ----------------------------------------------------------------------------
module aps_mac (
  input  logic                        clk,
  input  aps_pkg::mac_op_t            op,
  output logic [aps_pkg::CH_W-1:0]    res
);

  logic [2*aps_pkg::CH_W-1:0] prod;
  logic [2*aps_pkg::CH_W-1:0] sum;
  logic [aps_pkg::CH_W-1:0]   res_r;

  always_comb begin
    prod = (2*aps_pkg::CH_W)'(op.a) * (2*aps_pkg::CH_W)'(op.b);
    // a*b + a + b never exceeds 16 bits for 8-bit operands
    if (op.kind == aps_pkg::MAC_WEIGHT) begin
      sum = prod + (2*aps_pkg::CH_W)'(op.a) + (2*aps_pkg::CH_W)'(op.b);
    end else begin
      sum = prod;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= sum[2*aps_pkg::CH_W-1:aps_pkg::CH_W];
  end

  assign res = res_r;

endmodule

// File: hw/rtl/aps_frame.sv
// ----------------------------------------------------------------------------
// aps_frame
// frame memory, one read and one write port, zero sweep after reset
// ----------------------------------------------------------------------------
module aps_frame #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aps_pkg::fb_ctl_t            ctl,
  input  logic [ADDR_W-1:0]           rd_addr,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [aps_pkg::PIX_W-1:0]   wr_data,
  output logic [aps_pkg::PIX_W-1:0]   rd_data,
  output logic                        busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [aps_pkg::PIX_W-1:0] mem_r [DEPTH];
  logic [aps_pkg::PIX_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic [ADDR_W-1:0]         clr_addr_nxt;
  logic                      clr_busy_r;
  logic                      clr_busy_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // sweep has the write port until every entry is zero
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// File: hw/rtl/aps_checker.sv
// ----------------------------------------------------------------------------
// aps_checker
// port-level checks of the antialiased pixel splat block
// ----------------------------------------------------------------------------
module aps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [aps_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic [0:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [aps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [0:0]                       out_tuser,
  input logic                             out_tlast
);

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata)
      && $stable(in_tuser))
    else $error("stalled input changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // one item at a time: no input transaction while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid)
    else $error("input taken while result pending");

  // busy right after an input transaction
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transaction");

  // dropped result is the only one and carries no colour
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata[31:8] == 24'd0))
    else $error("dropped result malformed");

endmodule

bind antialiased_pixel_splat aps_checker u_aps_checker (.*);

// File: tb/splat_result_checker.sv
// ----------------------------------------------------------------------------
// splat_result_checker
// watches both streams of the splat block, mirrors its frame memory and
// compares every result transaction against the predicted pixel
// ----------------------------------------------------------------------------
module splat_result_checker #(
  parameter int MATRIX_WIDTH  = 16,
  parameter int MATRIX_HEIGHT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [aps_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [aps_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [0:0]                     out_tuser,
  input  logic                           out_tlast,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] col;
    logic [3:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dropped;
    logic       last;
  } pixel_result_t;

  logic [7:0]    frame_mirror [MATRIX_WIDTH*MATRIX_HEIGHT][3];
  pixel_result_t expected_pixels [$];
  int unsigned   failures = 0;

  task automatic log_failure(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      log_failure($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // bilinear weight of one corner, (a*b + a + b) >> 8
  function automatic int unsigned blend_weight(int unsigned a, int unsigned b);
    return ((a * b + a + b) >> 8) & 32'hff;
  endfunction

  task automatic predict_item(input logic [aps_pkg::IN_DATA_W-1:0] data,
                              input logic [0:0] cmd);
    int unsigned   col, row, fx, fy, addr, sum;
    int unsigned   wgt [4];
    int unsigned   paint [3];
    pixel_result_t res;
    col      = 32'(data[11:8]);
    row      = 32'(data[23:20]);
    fx       = 32'(data[7:0]);
    fy       = 32'(data[19:12]);
    paint[0] = 32'(data[31:24]);
    paint[1] = 32'(data[39:32]);
    paint[2] = 32'(data[47:40]);
    res      = '0;
    res.col  = 4'(col);
    res.row  = 4'(row);
    res.last = 1'b1;
    if (cmd == aps_pkg::CMD_READ) begin
      if (col >= MATRIX_WIDTH || row >= MATRIX_HEIGHT) begin
        res.dropped = 1'b1;
      end else begin
        addr      = row * MATRIX_WIDTH + col;
        res.red   = frame_mirror[addr][0];
        res.green = frame_mirror[addr][1];
        res.blue  = frame_mirror[addr][2];
      end
      expected_pixels.push_back(res);
    end else if (col + 1 >= MATRIX_WIDTH || row + 1 >= MATRIX_HEIGHT) begin
      // no room for the right or lower neighbour
      res.dropped = 1'b1;
      expected_pixels.push_back(res);
    end else begin
      wgt[0] = blend_weight(255 - fx, 255 - fy);
      wgt[1] = blend_weight(fx, 255 - fy);
      wgt[2] = blend_weight(255 - fx, fy);
      wgt[3] = blend_weight(fx, fy);
      for (int k = 0; k < 4; k++) begin
        addr = (row + k / 2) * MATRIX_WIDTH + col + k % 2;
        for (int ch = 0; ch < 3; ch++) begin
          sum = 32'(frame_mirror[addr][ch]) + ((paint[ch] * wgt[k]) >> 8);
          frame_mirror[addr][ch] = (sum > 255) ? 8'hff : 8'(sum);
        end
        res.col   = 4'(col + k % 2);
        res.row   = 4'(row + k / 2);
        res.red   = frame_mirror[addr][0];
        res.green = frame_mirror[addr][1];
        res.blue  = frame_mirror[addr][2];
        res.last  = (k == 3);
        expected_pixels.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      foreach (frame_mirror[a, ch]) frame_mirror[a][ch] = 8'h00;
      expected_pixels.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(in_tdata, in_tuser);
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          log_failure($sformatf("unexpected result col %0d row %0d",
                                out_tdata[3:0], out_tdata[7:4]));
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_col", 32'(out_tdata[3:0]), 32'(want.col));
          check_field("pixel_row", 32'(out_tdata[7:4]), 32'(want.row));
          check_field("red_out", 32'(out_tdata[15:8]), 32'(want.red));
          check_field("green_out", 32'(out_tdata[23:16]), 32'(want.green));
          check_field("blue_out", 32'(out_tdata[31:24]), 32'(want.blue));
          check_field("dropped", 32'(out_tuser[0]), 32'(want.dropped));
          check_field("last", 32'(out_tlast), 32'(want.last));
        end
      end
    end
    pending_results <= expected_pixels.size();
    mismatch_count  <= failures;
  end

endmodule

// File: tb/tb_antialiased_pixel_splat.sv
// ----------------------------------------------------------------------------
// tb_antialiased_pixel_splat
// drives splat and read transactions into the block with random gaps and
// back-pressure, a checker beside it predicts the frame memory and compares
// ----------------------------------------------------------------------------
module tb_antialiased_pixel_splat;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MATRIX_WIDTH  = 16;
  localparam int MATRIX_HEIGHT = 16;
  // the limit covers the reset sweep, which keeps in_tready low
  localparam int IDLE_LIMIT    = 2000;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // pos_x[11:0], pos_y[23:12], red_in[31:24], green_in[39:32], blue_in[47:40]
  logic [aps_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  // command[0]
  logic [0:0]                     in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // pixel_col[3:0], pixel_row[7:4], red_out[15:8], green_out[23:16],
  // blue_out[31:24]
  logic [aps_pkg::OUT_DATA_W-1:0] out_tdata;
  // dropped[0]
  logic [0:0]                     out_tuser;
  logic                           out_tlast;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold  = 0;
  int unsigned ready_pick;
  // when set neither side idles
  logic        steady_flow = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  antialiased_pixel_splat #(
    .MATRIX_WIDTH (MATRIX_WIDTH),
    .MATRIX_HEIGHT(MATRIX_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  splat_result_checker #(
    .MATRIX_WIDTH (MATRIX_WIDTH),
    .MATRIX_HEIGHT(MATRIX_HEIGHT)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // result side back-pressure: runs of ready, mostly short stalls, rare long ones
  always @(posedge clk) begin
    if (steady_flow) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 12);
      end else if (ready_pick < 95) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(15, 50);
      end
    end
  end

  // watchdog: gives up when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one input transaction, preceded by a random gap unless the flow is steady
  task automatic send_item(input aps_pkg::cmd_t cmd, input logic [11:0] px,
                           input logic [11:0] py, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady_flow || pick < 70) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(12, 40);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {blue, green, red, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // fraction byte with the extremes favored
  function automatic logic [7:0] rand_frac();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 8'h00;
    if (pick < 16) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned pick;
    logic [3:0]  col, row;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // read of a cleared pixel, fraction bits must be ignored
    send_item(aps_pkg::CMD_READ, 12'h0ff, 12'h0ff, 8'hff, 8'hff, 8'hff);
    // zero fraction: all weight on the upper left pixel
    send_item(aps_pkg::CMD_SPLAT, 12'h000, 12'h000, 8'hff, 8'hff, 8'hff);
    // full fraction: weight mostly on the lower right pixel
    send_item(aps_pkg::CMD_SPLAT, 12'h0ff, 12'h0ff, 8'hff, 8'h80, 8'h01);
    // half fraction spreads evenly
    send_item(aps_pkg::CMD_SPLAT, 12'h380, 12'h780, 8'hff, 8'hff, 8'hff);
    // last position that still has both neighbours
    send_item(aps_pkg::CMD_SPLAT, 12'heff, 12'he00, 8'hff, 8'h00, 8'hff);
    // no right neighbour, no lower neighbour, neither
    send_item(aps_pkg::CMD_SPLAT, 12'hf40, 12'h340, 8'h12, 8'h34, 8'h56);
    send_item(aps_pkg::CMD_SPLAT, 12'h240, 12'hf40, 8'h12, 8'h34, 8'h56);
    send_item(aps_pkg::CMD_SPLAT, 12'hfff, 12'hfff, 8'hff, 8'hff, 8'hff);
    // black splat leaves the pixels unchanged
    send_item(aps_pkg::CMD_SPLAT, 12'h155, 12'h1aa, 8'h00, 8'h00, 8'h00);
    // pile up on one pixel until all channels saturate
    repeat (5) send_item(aps_pkg::CMD_SPLAT, 12'h800, 12'h800, 8'hff, 8'hc0, 8'h70);
    send_item(aps_pkg::CMD_READ, 12'h800, 12'h800, 8'h00, 8'h00, 8'h00);
    // corner pixels, one touched by the edge splat above
    send_item(aps_pkg::CMD_READ, 12'hfff, 12'hfff, 8'h00, 8'h00, 8'h00);
    send_item(aps_pkg::CMD_READ, 12'hf00, 12'he00, 8'hff, 8'hff, 8'hff);
    // pressure: let everything drain before going on
    wait_for_results();
    send_item(aps_pkg::CMD_READ, 12'h1ff, 12'h100, 8'h00, 8'h00, 8'h00);
    send_item(aps_pkg::CMD_SPLAT, 12'h701, 12'h2fe, 8'h01, 8'hfe, 8'h80);
    send_item(aps_pkg::CMD_READ, 12'h700, 12'h300, 8'h00, 8'h00, 8'h00);

    // ---- random part ----
    for (int n = 0; n < 290; n++) begin
      // switch between stretches with and without idling now and then
      if (n % 70 == 69) begin
        steady_flow <= ~steady_flow;
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // well-formed splat, a quarter of them into a small hot spot
        if ($urandom_range(0, 3) == 0) begin
          col = 4'($urandom_range(5, 6));
          row = 4'($urandom_range(5, 6));
        end else begin
          col = 4'($urandom_range(0, 14));
          row = 4'($urandom_range(0, 14));
        end
        send_item(aps_pkg::CMD_SPLAT, {col, rand_frac()}, {row, rand_frac()},
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
        // splat on the right or bottom edge, must be dropped
        if ($urandom_range(0, 1) == 0) begin
          col = 4'hf;
          row = 4'($urandom_range(0, 15));
        end else begin
          col = 4'($urandom_range(0, 15));
          row = 4'hf;
        end
        send_item(aps_pkg::CMD_SPLAT, {col, rand_frac()}, {row, rand_frac()},
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else begin
        // read anywhere, colour fields are don't-care
        send_item(aps_pkg::CMD_READ, 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end

    // ---- wrap up ----
    wait_for_results();
    // give stray results time to show up
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/aps_pkg.sv
hw/rtl/aps_mac.sv
hw/rtl/aps_frame.sv
hw/rtl/antialiased_pixel_splat.sv
hw/rtl/aps_checker.sv
tb/splat_result_checker.sv
tb/tb_antialiased_pixel_splat.sv
